@@ rtl/rumble_effect_slot_mixer_core_macros.svh @@
// ----------------------------------------------------------------------------
// rumble_effect_slot_mixer_core_macros
// Assertion macros shared by the slot mixer RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RUMBLE_EFFECT_SLOT_MIXER_CORE_MACROS_SVH
`define RUMBLE_EFFECT_SLOT_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RSMIX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsmix assertion failed");

// next-cycle implication
`define RSMIX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsmix assertion failed");

`else

`define RSMIX_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RSMIX_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/rsmix_pkg.sv @@
// ----------------------------------------------------------------------------
// rsmix_pkg
// Request codes, status codes and the beat types shared by the slot mixer.
// ----------------------------------------------------------------------------
package rsmix_pkg;

   localparam int LEVEL_BITS = 7;
   localparam int MAG_SHIFT  = 9;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'h7f;

   localparam logic [2:0] MODE_UPLOAD = 3'd0;
   localparam logic [2:0] MODE_UPDATE = 3'd1;
   localparam logic [2:0] MODE_PLAY   = 3'd2;
   localparam logic [2:0] MODE_STOP   = 3'd3;
   localparam logic [2:0] MODE_ERASE  = 3'd4;
   localparam logic [2:0] MODE_FLUSH  = 3'd5;
   localparam logic [2:0] MODE_NONFF  = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_NOSPACE = 3'd2;
   localparam logic [2:0] ST_DENIED  = 3'd3;
   localparam logic [2:0] ST_REPLAY  = 3'd4;

   typedef struct packed {
      logic [2:0]            mode;
      logic [2:0]            slot;
      logic                  rumble;
      logic [LEVEL_BITS-1:0] left;
      logic [LEVEL_BITS-1:0] right;
      logic [15:0]           dly;
      logic [15:0]           len;
   } cmd_type;

   // walks the cell chain one cell per cycle
   typedef struct packed {
      logic                  valid;
      logic [2:0]            status;
      logic [2:0]            aslot;
      logic                  pkt;
      logic                  taken;
      logic [LEVEL_BITS-1:0] sum_l;
      logic [LEVEL_BITS-1:0] sum_r;
   } wave_type;

endpackage

@@ rtl/rsmix_cell.sv @@
// ----------------------------------------------------------------------------
// rsmix_cell
// One effect slot: applies the request to its own slot as the wave passes,
// adds its post-request levels to the running saturated sums while it plays.
// ----------------------------------------------------------------------------
module rsmix_cell #(
   parameter int OWNER_BITS = 16,
   parameter int CELL_ID    = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rsmix_pkg::cmd_type      cmd,
   input  logic [OWNER_BITS-1:0]   who,
   input  rsmix_pkg::wave_type     wave_in,
   output rsmix_pkg::wave_type     wave_out
);

   logic                                used_ff, used_in;
   logic                                play_ff, play_in;
   logic [OWNER_BITS-1:0]               owner_ff, owner_in;
   logic [rsmix_pkg::LEVEL_BITS-1:0]    left_ff, left_in;
   logic [rsmix_pkg::LEVEL_BITS-1:0]    right_ff, right_in;
   logic [15:0]                         dly_ff, dly_in;
   logic [15:0]                         len_ff, len_in;
   rsmix_pkg::wave_type                 wave_ff, wave_in_nxt;

   logic                                hit;
   logic                                acc;
   logic [rsmix_pkg::LEVEL_BITS:0]      add_l, add_r;

   assign hit = (32'(cmd.slot) == CELL_ID);
   assign acc = hit && used_ff && ((who == '0) || (owner_ff == who));

   always_comb begin
      used_in     = used_ff;
      play_in     = play_ff;
      owner_in    = owner_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      dly_in      = dly_ff;
      len_in      = len_ff;
      wave_in_nxt = wave_in;
      add_l       = '0;
      add_r       = '0;
      if (wave_in.valid) begin
         case (cmd.mode)
            rsmix_pkg::MODE_UPLOAD: begin
               if (cmd.rumble && !wave_in.taken && !used_ff) begin
                  used_in            = 1'b1;
                  play_in            = 1'b0;
                  owner_in           = who;
                  left_in            = cmd.left;
                  right_in           = cmd.right;
                  dly_in             = cmd.dly;
                  len_in             = cmd.len;
                  wave_in_nxt.taken  = 1'b1;
                  wave_in_nxt.status = rsmix_pkg::ST_OK;
                  wave_in_nxt.aslot  = 3'(CELL_ID);
               end
            end
            rsmix_pkg::MODE_UPDATE: begin
               if (cmd.rumble && acc) begin
                  if (play_ff && ((dly_ff != cmd.dly) || (len_ff != cmd.len))) begin
                     wave_in_nxt.status = rsmix_pkg::ST_REPLAY;
                  end else begin
                     left_in            = cmd.left;
                     right_in           = cmd.right;
                     dly_in             = cmd.dly;
                     len_in             = cmd.len;
                     wave_in_nxt.status = rsmix_pkg::ST_OK;
                     wave_in_nxt.pkt    = play_ff;
                  end
               end
            end
            rsmix_pkg::MODE_PLAY, rsmix_pkg::MODE_STOP, rsmix_pkg::MODE_ERASE: begin
               if (acc) begin
                  play_in            = (cmd.mode == rsmix_pkg::MODE_PLAY);
                  wave_in_nxt.status = rsmix_pkg::ST_OK;
                  wave_in_nxt.pkt    = 1'b1;
                  if (cmd.mode == rsmix_pkg::MODE_ERASE) begin
                     used_in = 1'b0;
                  end
               end
            end
            rsmix_pkg::MODE_FLUSH: begin
               if (used_ff && (owner_ff == who)) begin
                  used_in         = 1'b0;
                  play_in         = 1'b0;
                  wave_in_nxt.pkt = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // post-request contribution, sums saturate at full scale
         if (used_in && play_in) begin
            add_l = {1'b0, wave_in.sum_l} + {1'b0, left_in};
            add_r = {1'b0, wave_in.sum_r} + {1'b0, right_in};
         end else begin
            add_l = {1'b0, wave_in.sum_l};
            add_r = {1'b0, wave_in.sum_r};
         end
         wave_in_nxt.sum_l = add_l[rsmix_pkg::LEVEL_BITS] ? rsmix_pkg::LEVEL_MAX :
                             add_l[rsmix_pkg::LEVEL_BITS-1:0];
         wave_in_nxt.sum_r = add_r[rsmix_pkg::LEVEL_BITS] ? rsmix_pkg::LEVEL_MAX :
                             add_r[rsmix_pkg::LEVEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         play_ff <= 1'b0;
         wave_ff <= '0;
      end else begin
         used_ff <= used_in;
         play_ff <= play_in;
         wave_ff <= wave_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      dly_ff   <= dly_in;
      len_ff   <= len_in;
   end

   assign wave_out = wave_ff;

endmodule

@@ rtl/rumble_effect_slot_mixer_core.sv @@
// ----------------------------------------------------------------------------
// rumble_effect_slot_mixer_core
// Eight-slot rumble effect table with owner checks and a saturated mixer.
// ----------------------------------------------------------------------------
// Each request beat launches a wave down a chain of NUM_SLOTS slot cells,
// one cell per cycle; every cell applies the request to its own slot and
// adds its levels to the running motor sums. The result passes the head
// register and the cells toward the response register, and a new request is
// only taken once the last result has moved into the response register.
// A finished response may wait on rsp_stall while the next request runs.
module rumble_effect_slot_mixer_core #(
   parameter int NUM_SLOTS  = 8,
   parameter int OWNER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_requester,
   input  logic        req_is_rumble,
   input  logic [15:0] req_strong_magnitude,
   input  logic [15:0] req_weak_magnitude,
   input  logic [15:0] req_replay_delay,
   input  logic [15:0] req_replay_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_assigned_slot,
   output logic        rsp_packet_sent,
   output logic [6:0]  rsp_left_level,
   output logic [6:0]  rsp_right_level
);

`include "rumble_effect_slot_mixer_core_macros.svh"

   rsmix_pkg::cmd_type      cmd_ff, cmd_in;
   logic [OWNER_BITS-1:0]   who_ff, who_in;
   rsmix_pkg::wave_type     head_ff, head_in;
   rsmix_pkg::wave_type     park_ff, park_in;
   rsmix_pkg::wave_type     rsp_ff, rsp_in;
   logic                    busy_ff, busy_in;
   rsmix_pkg::wave_type     chain [0:NUM_SLOTS];
   rsmix_pkg::wave_type     tail;
   logic [NUM_SLOTS:0]      wave_vld;
   logic                    accept;
   logic                    rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_ff.valid || !rsp_stall;
   assign tail     = chain[NUM_SLOTS];

   always_comb begin
      cmd_in  = cmd_ff;
      who_in  = who_ff;
      head_in = '0;
      if (accept) begin
         cmd_in.mode   = req_mode;
         cmd_in.slot   = req_slot;
         cmd_in.rumble = req_is_rumble;
         cmd_in.left   = 7'(req_weak_magnitude >> rsmix_pkg::MAG_SHIFT);
         cmd_in.right  = 7'(req_strong_magnitude >> rsmix_pkg::MAG_SHIFT);
         cmd_in.dly    = req_replay_delay;
         cmd_in.len    = req_replay_length;
         who_in        = OWNER_BITS'(req_requester);
         head_in.valid = 1'b1;
         case (req_mode)
            rsmix_pkg::MODE_UPLOAD: begin
               head_in.status = req_is_rumble ? rsmix_pkg::ST_NOSPACE :
                                                rsmix_pkg::ST_INVALID;
            end
            rsmix_pkg::MODE_UPDATE: begin
               head_in.status = req_is_rumble ? rsmix_pkg::ST_DENIED :
                                                rsmix_pkg::ST_INVALID;
               head_in.aslot  = req_slot;
            end
            rsmix_pkg::MODE_PLAY, rsmix_pkg::MODE_STOP, rsmix_pkg::MODE_ERASE: begin
               head_in.status = rsmix_pkg::ST_DENIED;
               head_in.aslot  = req_slot;
            end
            rsmix_pkg::MODE_FLUSH: begin
               head_in.status = rsmix_pkg::ST_OK;
            end
            default: begin
               head_in.status = rsmix_pkg::ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      park_in = park_ff;
      rsp_in  = rsp_ff;
      if (rsp_free) begin
         rsp_in.valid = 1'b0;
      end
      if (tail.valid) begin
         if (rsp_free) begin
            rsp_in  = tail;
            busy_in = 1'b0;
         end else begin
            park_in = tail;
         end
      end else if (park_ff.valid && rsp_free) begin
         rsp_in        = park_ff;
         park_in.valid = 1'b0;
         busy_in       = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         head_ff <= '0;
         park_ff <= '0;
         rsp_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         head_ff <= head_in;
         park_ff <= park_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      who_ff <= who_in;
   end

   assign chain[0] = head_ff;

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      rsmix_cell #(
         .OWNER_BITS (OWNER_BITS),
         .CELL_ID    (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .who      (who_ff),
         .wave_in  (chain[k]),
         .wave_out (chain[k+1])
      );
   end

   for (genvar k = 0; k <= NUM_SLOTS; k++) begin : g_vld
      assign wave_vld[k] = chain[k].valid;
   end

   assign req_stall         = busy_ff;
   assign rsp_valid         = rsp_ff.valid;
   assign rsp_status        = rsp_ff.status;
   assign rsp_assigned_slot = rsp_ff.aslot;
   assign rsp_packet_sent   = rsp_ff.pkt;
   assign rsp_left_level    = rsp_ff.pkt ? rsp_ff.sum_l : '0;
   assign rsp_right_level   = rsp_ff.pkt ? rsp_ff.sum_r : '0;

   `RSMIX_ASSERT_NOW(a_one_wave, clock, reset, 1'b1, $onehot0({wave_vld, park_ff.valid}))
   `RSMIX_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy_ff)
   `RSMIX_ASSERT_NOW(a_idle_empty, clock, reset, !busy_ff, (wave_vld == '0) && !park_ff.valid)
   `RSMIX_ASSERT_NXT(a_tail_park, clock, reset, tail.valid && !rsp_free, park_ff.valid)

endmodule
